// ----- rtl/doubly_linked_list_manager_assert.svh -----
// assertion macros for the list manager
`ifndef DOUBLY_LINKED_LIST_MANAGER_ASSERT_SVH
`define DOUBLY_LINKED_LIST_MANAGER_ASSERT_SVH
// implication checked every cycle outside reset
`define DLL_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// implication checked in the following cycle
`define DLL_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ----- rtl/dll_pkg.sv -----
package dll_pkg;
   localparam int NODES = 16;
   localparam int DATA_WIDTH = 32;
   localparam int HW = 5;
   localparam int IW = 4;
   localparam logic [HW-1:0] SENT = HW'(NODES);

   typedef enum logic [2:0] {
      CMD_PUSH_BACK = 3'd0, CMD_PUSH_FRONT = 3'd1, CMD_POP_BACK = 3'd2,
      CMD_POP_FRONT = 3'd3, CMD_INSERT = 3'd4, CMD_ERASE = 3'd5,
      CMD_FIND = 3'd6, CMD_CLEAR = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_BAD = 3'd3, ST_NOT_FOUND = 3'd4
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic latch;       // capture request word
      logic alloc;       // link new node before target
      logic unlink;      // unlink target
      logic clear;       // pool reset
      logic find_start;  // cur <= head
      logic find_step;   // cur <= next[cur]
      logic done;        // drive result
      status_type st;
      logic [HW-1:0] rh_sel_cur; // result handle is cur
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] cmd;
      logic tgt_bad;     // target handle invalid for push or insert
      logic erase_bad;
      logic pool_empty;
      logic list_empty;
      logic cur_match;
      logic cur_end;     // cur is sentinel/out of range or steps exhausted
   } sts_type;
endpackage

// ----- rtl/dll_datapath.sv -----
module dll_datapath import dll_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic [2:0] req_cmd,
   input  logic signed [31:0] req_item_value,
   input  logic [4:0] req_node_handle,
   input  ctl_type ctl,
   output sts_type sts,
   output logic [HW-1:0] alloc_handle,
   output logic [HW-1:0] cur_handle,
   output logic signed [31:0] pop_value,
   output logic [HW-1:0] len
);
   logic [DATA_WIDTH-1:0] val_mem [NODES];
   logic [HW-1:0] next_ff [NODES+1];
   logic [HW-1:0] prev_ff [NODES+1];
   logic [NODES-1:0] use_ff;
   logic [IW-1:0] fstk_ff [NODES];
   logic [HW-1:0] fcnt_ff, len_ff;
   logic [2:0] cmd_ff;
   logic [DATA_WIDTH-1:0] v_ff;
   logic [4:0] h_ff;
   logic [HW-1:0] cur_ff, steps_ff;
   logic [HW-1:0] tgt, p, n, top;
   logic [IW-1:0] ti;

   // target selection
   always_comb begin
      case (cmd_ff)
         CMD_PUSH_BACK:  tgt = SENT;
         CMD_PUSH_FRONT: tgt = next_ff[NODES];
         CMD_POP_BACK:   tgt = prev_ff[NODES];
         CMD_POP_FRONT:  tgt = next_ff[NODES];
         default:        tgt = h_ff;
      endcase
   end
   assign ti = tgt[IW-1:0];
   assign top = HW'(fstk_ff[IW'(fcnt_ff - 1'b1)]);
   assign p = (tgt <= SENT) ? prev_ff[tgt] : SENT;
   assign n = (tgt <= SENT) ? next_ff[tgt] : SENT;

   assign sts.cmd = cmd_ff;
   assign sts.tgt_bad = (tgt > SENT) || (tgt < SENT && !use_ff[ti]);
   assign sts.erase_bad = (tgt >= SENT) || !use_ff[ti];
   assign sts.pool_empty = (fcnt_ff == '0);
   assign sts.list_empty = (len_ff == '0) || (next_ff[NODES] == SENT);
   assign sts.cur_match = (cur_ff < SENT) && (val_mem[cur_ff[IW-1:0]] == v_ff);
   assign sts.cur_end = (cur_ff >= SENT) || (steps_ff >= SENT);

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int i = 0; i <= NODES; i++) begin
            next_ff[i] <= SENT;
            prev_ff[i] <= SENT;
         end
         for (int i = 0; i < NODES; i++) fstk_ff[i] <= IW'(NODES - 1 - i);
         use_ff <= '0;
         fcnt_ff <= HW'(NODES);
         len_ff <= '0;
      end else if (ctl.alloc) begin
         val_mem[top[IW-1:0]] <= v_ff;
         use_ff[top[IW-1:0]] <= 1'b1;
         next_ff[p] <= top;
         prev_ff[top] <= p;
         next_ff[top] <= tgt;
         prev_ff[tgt] <= top;
         fcnt_ff <= fcnt_ff - 1'b1;
         len_ff <= len_ff + 1'b1;
      end else if (ctl.unlink) begin
         next_ff[p] <= n;
         prev_ff[n] <= p;
         use_ff[ti] <= 1'b0;
         fstk_ff[fcnt_ff[IW-1:0]] <= ti;
         fcnt_ff <= fcnt_ff + 1'b1;
         len_ff <= len_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff <= req_cmd;
         v_ff <= req_item_value;
         h_ff <= req_node_handle;
      end
      if (ctl.alloc) alloc_handle <= top;
      if (ctl.unlink) pop_value <= val_mem[ti];
      if (ctl.find_start) begin
         cur_ff <= next_ff[NODES];
         steps_ff <= '0;
      end else if (ctl.find_step) begin
         cur_ff <= (cur_ff <= SENT) ? next_ff[cur_ff] : SENT;
         steps_ff <= steps_ff + 1'b1;
      end
   end

   assign cur_handle = cur_ff;
   assign len = len_ff;
endmodule

// ----- rtl/dll_ctrl.sv -----
module dll_ctrl import dll_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  sts_type sts,
   output logic busy,
   output ctl_type ctl
);
   `include "doubly_linked_list_manager_assert.svh"
   typedef enum logic [2:0] {S_IDLE, S_DEC, S_WORK, S_FIND, S_DONE} state_type;
   state_type state_ff;
   status_type st_ff;
   logic cur_ff;
   logic is_find;

   assign busy = (state_ff != S_IDLE);
   assign is_find = (sts.cmd == CMD_FIND);

   always_comb begin
      ctl = '0;
      ctl.st = st_ff;
      ctl.rh_sel_cur = HW'(cur_ff);
      ctl.latch = (state_ff == S_IDLE) && start;
      if (state_ff == S_WORK) begin
         if (st_ff == ST_OK) begin
            case (sts.cmd)
               CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: ctl.alloc = 1'b1;
               CMD_POP_BACK, CMD_POP_FRONT, CMD_ERASE: ctl.unlink = 1'b1;
               CMD_CLEAR: ctl.clear = 1'b1;
               default: ctl.find_start = 1'b1;
            endcase
         end
      end
      if (state_ff == S_FIND && !sts.cur_match && !sts.cur_end) ctl.find_step = 1'b1;
      ctl.done = (state_ff == S_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff <= ST_OK;
         cur_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (start) state_ff <= S_DEC;
            S_DEC: begin
               state_ff <= S_WORK;
               cur_ff <= 1'b0;
               case (sts.cmd)
                  CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT:
                     st_ff <= sts.tgt_bad ? ST_BAD : (sts.pool_empty ? ST_FULL : ST_OK);
                  CMD_POP_BACK, CMD_POP_FRONT:
                     st_ff <= (sts.list_empty || sts.erase_bad) ? ST_EMPTY : ST_OK;
                  CMD_ERASE: st_ff <= sts.erase_bad ? ST_BAD : ST_OK;
                  default: st_ff <= ST_OK;
               endcase
            end
            S_WORK: state_ff <= (is_find && st_ff == ST_OK) ? S_FIND : S_DONE;
            S_FIND: begin
               if (sts.cur_match) begin
                  cur_ff <= 1'b1;
                  state_ff <= S_DONE;
               end else if (sts.cur_end) begin
                  st_ff <= ST_NOT_FOUND;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `DLL_ASSERT_NEXT(a_done_idle, clock, reset, state_ff == S_DONE, state_ff == S_IDLE)
   `DLL_ASSERT_IMP(a_one_op, clock, reset, 1'b1,
      $onehot0({ctl.alloc, ctl.unlink, ctl.clear, ctl.find_start}))
   `DLL_ASSERT_IMP(a_ok_alloc, clock, reset, ctl.alloc, !sts.pool_empty)
   `DLL_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
endmodule

// ----- rtl/doubly_linked_list_manager.sv -----
// doubly linked list manager over a 16-node pool with a sentinel
// every command runs decode, work and result states in order; find adds a walk state
// find: the walk compares nodes from the head until a match, the sentinel or the step limit
// a new command is taken only when idle; busy is high until the result cycle ends
// the receiver cannot stall: each result word shows for exactly one cycle
// reset (synchronous, active high) empties the list and refills the free stack
module doubly_linked_list_manager import dll_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [2:0] req_cmd,
   input  logic signed [31:0] req_item_value,
   input  logic [4:0] req_node_handle,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [4:0] rsp_result_handle,
   output logic signed [31:0] rsp_result_value,
   output logic rsp_is_empty,
   output logic [4:0] rsp_length
);
   ctl_type ctl;
   sts_type sts;
   logic [HW-1:0] alloc_handle, cur_handle, len;
   logic signed [31:0] pop_value;
   logic is_alloc, is_pop;

   // controller sequences decode, link update, walk and result
   dll_ctrl u_ctrl (.clock, .reset, .start, .sts, .busy, .ctl);

   // link tables, free stack and value store
   dll_datapath u_dp (
      .clock, .reset, .req_cmd, .req_item_value, .req_node_handle,
      .ctl, .sts, .alloc_handle, .cur_handle, .pop_value, .len
   );

   assign is_alloc = (sts.cmd == CMD_PUSH_BACK) || (sts.cmd == CMD_PUSH_FRONT)
                     || (sts.cmd == CMD_INSERT);
   assign is_pop = (sts.cmd == CMD_POP_BACK) || (sts.cmd == CMD_POP_FRONT)
                   || (sts.cmd == CMD_ERASE);

   // result word
   assign rsp_valid = ctl.done;
   assign rsp_status = ctl.st;
   always_comb begin
      rsp_result_handle = SENT;
      rsp_result_value = '0;
      if (ctl.st == ST_OK) begin
         if (is_alloc) rsp_result_handle = alloc_handle;
         if (ctl.rh_sel_cur[0]) rsp_result_handle = cur_handle;
         if (is_pop) rsp_result_value = pop_value;
      end
   end
   assign rsp_is_empty = (len == '0);
   assign rsp_length = len;
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import dll_pkg::*;

   // one expected response word
   typedef struct {
      status_type    st;
      logic [4:0]    rh;
      logic [31:0]   rv;
      logic          emp;
      logic [4:0]    len;
   } list_rsp_type;

   localparam int STALL_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_cmd = '0;
   logic signed [31:0] req_item_value = '0;
   logic [4:0] req_node_handle = '0;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic [4:0] rsp_result_handle;
   logic signed [31:0] rsp_result_value;
   logic rsp_is_empty;
   logic [4:0] rsp_length;

   doubly_linked_list_manager uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_item_value(req_item_value),
      .req_node_handle(req_node_handle), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_result_handle(rsp_result_handle),
      .rsp_result_value(rsp_result_value), .rsp_is_empty(rsp_is_empty),
      .rsp_length(rsp_length)
   );

   always #5 clock = ~clock;

   // shadow copy of the list state
   logic [31:0] node_val [NODES];
   logic [4:0]  link_next [NODES+1];
   logic [4:0]  link_prev [NODES+1];
   bit          node_used [NODES];
   logic [3:0]  free_stk [NODES];
   int          free_cnt;
   int          list_len;

   list_rsp_type pending_rsp[$];
   int errors = 0;
   int idle_pct = 0;
   int quiet_cycles = 0;
   bit word_taken;

   // put the pool back in its reset order
   function automatic void shadow_clear();
      for (int i = 0; i < NODES; i++) begin
         node_val[i] = '0;
         node_used[i] = 0;
         free_stk[i] = 4'(NODES - 1 - i);
      end
      for (int i = 0; i <= NODES; i++) begin
         link_next[i] = SENT;
         link_prev[i] = SENT;
      end
      free_cnt = NODES;
      list_len = 0;
   endfunction

   function automatic void shadow_unlink(int pos);
      logic [4:0] p;
      logic [4:0] n;
      p = link_prev[pos];
      n = link_next[pos];
      link_next[p] = n;
      link_prev[n] = p;
      node_used[pos] = 0;
      free_stk[free_cnt] = 4'(pos);
      free_cnt++;
      list_len--;
   endfunction

   // apply one command to the shadow list and return the response word
   function automatic list_rsp_type list_apply(cmd_type c, logic [31:0] v, logic [4:0] h);
      list_rsp_type r;
      int t;
      int n;
      int cur;
      r.st = ST_OK;
      r.rh = SENT;
      r.rv = '0;
      case (c)
         CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
            if (c == CMD_PUSH_BACK) t = NODES;
            else if (c == CMD_PUSH_FRONT) t = link_next[NODES];
            else t = h;
            // handle is checked before the pool
            if (t > NODES || (t < NODES && !node_used[t])) r.st = ST_BAD;
            else if (free_cnt == 0) r.st = ST_FULL;
            else begin
               free_cnt--;
               n = free_stk[free_cnt];
               node_val[n] = v;
               node_used[n] = 1;
               link_next[link_prev[t]] = 5'(n);
               link_prev[n] = link_prev[t];
               link_next[n] = 5'(t);
               link_prev[t] = 5'(n);
               list_len++;
               r.rh = 5'(n);
            end
         end
         CMD_POP_BACK, CMD_POP_FRONT: begin
            if (list_len == 0) r.st = ST_EMPTY;
            else begin
               t = (c == CMD_POP_BACK) ? link_prev[NODES] : link_next[NODES];
               r.rv = node_val[t];
               shadow_unlink(t);
            end
         end
         CMD_ERASE: begin
            // sentinel and out-of-range handles are refused
            if (h >= NODES || !node_used[h]) r.st = ST_BAD;
            else begin
               r.rv = node_val[h];
               shadow_unlink(h);
            end
         end
         CMD_FIND: begin
            r.st = ST_NOT_FOUND;
            cur = link_next[NODES];
            for (int s = 0; s < NODES && cur < NODES; s++) begin
               if (node_val[cur] == v) begin
                  r.st = ST_OK;
                  r.rh = 5'(cur);
                  break;
               end
               cur = link_next[cur];
            end
         end
         default: shadow_clear();
      endcase
      r.emp = (list_len == 0);
      r.len = 5'(list_len);
      return r;
   endfunction

   task automatic report(string field, longint got, longint want);
      $display("mismatch in %s at %0t: got %0d, want %0d", field, $realtime, got, want);
      errors++;
   endtask

   // response checker: the receiver never stalls, every strobe is a word
   always @(posedge clock) begin
      list_rsp_type w;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("unexpected response word at %0t", $realtime);
            errors++;
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_status !== w.st) report("status", rsp_status, w.st);
            if (rsp_result_handle !== w.rh) report("handle", rsp_result_handle, w.rh);
            if (rsp_result_value !== w.rv)
               report("value", rsp_result_value, $signed(w.rv));
            if (rsp_is_empty !== w.emp) report("empty", rsp_is_empty, w.emp);
            if (rsp_length !== w.len) report("length", rsp_length, w.len);
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // send one command word and wait until it is taken
   task automatic send_word(cmd_type c, logic [31:0] v, logic [4:0] h);
      start <= 1'b1;
      req_cmd <= c;
      req_item_value <= v;
      req_node_handle <= h;
      word_taken = 0;
      while (!word_taken) begin
         @(posedge clock);
         word_taken = !busy;
      end
      pending_rsp.push_back(list_apply(c, v, h));
      // sender gap, only when start really drops
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // pick a handle: mostly live nodes or the sentinel, sometimes anything
   function automatic logic [4:0] pick_handle();
      int k;
      k = $urandom_range(99);
      if (k < 15) return 5'($urandom_range(31));
      if (k < 25) return SENT;
      for (int tries = 0; tries < 8; tries++) begin
         k = $urandom_range(NODES - 1);
         if (node_used[k]) return 5'(k);
      end
      return 5'($urandom_range(NODES - 1));
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2, 3: return 32'($urandom_range(7));
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      wait_drained();
      idle_pct = 0;
      send_word(CMD_POP_BACK, 0, 0);
      send_word(CMD_POP_FRONT, 0, 0);
      send_word(CMD_FIND, 0, 0);
      send_word(CMD_ERASE, 0, SENT);
      send_word(CMD_ERASE, 32'hffff_ffff, 5'd31);
      send_word(CMD_INSERT, 1, 5'd20);
      send_word(CMD_INSERT, 2, 5'd3);
      send_word(CMD_INSERT, 32'h8000_0000, SENT);
      send_word(CMD_PUSH_FRONT, 32'h7fff_ffff, 0);
      for (int i = 0; i < 14; i++) send_word(CMD_PUSH_BACK, 32'(i * 3 - 20), 0);
      // pool is full now
      send_word(CMD_PUSH_BACK, 5, 0);
      send_word(CMD_INSERT, 6, 5'd0);
      send_word(CMD_FIND, 32'h7fff_ffff, 0);
      send_word(CMD_ERASE, 32'h0, 5'd5);
      send_word(CMD_POP_BACK, 0, 0);
      send_word(CMD_POP_FRONT, 0, 0);
      send_word(CMD_CLEAR, 0, 0);
      send_word(CMD_PUSH_BACK, 9, 0);
   endtask

   task automatic test_random(int pct, int count);
      cmd_type c;
      int k;
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         if (k < 22) c = CMD_PUSH_BACK;
         else if (k < 36) c = CMD_PUSH_FRONT;
         else if (k < 46) c = CMD_POP_BACK;
         else if (k < 56) c = CMD_POP_FRONT;
         else if (k < 70) c = CMD_INSERT;
         else if (k < 82) c = CMD_ERASE;
         else if (k < 97) c = CMD_FIND;
         else c = CMD_CLEAR;
         send_word(c, pick_value(), pick_handle());
      end
   endtask

   initial begin
      shadow_clear();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(0, 460);
      // hold off until everything is back, then carry on
      wait_drained();
      test_random(59, 460);
      test_random(6, 460);
      wait_drained();
      test_random(59, 460);
      wait_drained();
      repeat (40) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
